// ----- src/smpq_pkg.sv -----
// types and constants shared by the stable max priority queue files
`timescale 1ns / 1ps
package smpq_pkg;

    localparam int ID_W       = 10;
    localparam int PRIO_W     = 8;
    localparam int CAP_W      = 5;
    localparam int HELD_W     = 5;
    localparam int SMPQ_DEPTH = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

// ----- src/smpq_if.sv -----
// request and response channel interfaces
`timescale 1ns / 1ps
interface smpq_req_if import smpq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ID_W-1:0]   requester_id;
    logic [PRIO_W-1:0] priority_level;

    modport source (
        output valid, req_type, requester_id, priority_level,
        input  ready
    );
    modport sink (
        input  valid, req_type, requester_id, priority_level,
        output ready
    );
endinterface

interface smpq_rsp_if import smpq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   out_id;
    logic [PRIO_W-1:0] out_priority;
    logic              out_valid;
    logic              insert_rejected;
    logic [HELD_W-1:0] held_count;

    modport source (
        output valid, out_id, out_priority, out_valid, insert_rejected, held_count,
        input  ready
    );
    modport sink (
        input  valid, out_id, out_priority, out_valid, insert_rejected, held_count,
        output ready
    );
endinterface

// ----- src/smpq_cell.sv -----
// one place of the sorted queue: holds an entry, shifts in from either neighbour
`timescale 1ns / 1ps
module smpq_cell import smpq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occupied,
    input  t_entry    i_left_entry,
    input  logic      i_left_ge,
    input  t_entry    i_right_entry,
    output t_entry    o_entry,
    output logic      o_ge
);

    t_entry r_entry;
    t_entry n_entry;

    // held entry stays ahead of the new one (equal priority: older stays ahead)
    assign o_ge    = i_occupied && (r_entry.prio >= i_ctl.new_entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (o_ge) begin
                n_entry = r_entry;
            end else if (i_left_ge) begin
                n_entry = i_ctl.new_entry;
            end else begin
                n_entry = i_left_entry;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- src/stable_max_priority_queue_core.sv -----
// top level of the stable max priority queue: cell chain, count and result register
`timescale 1ns / 1ps
// A bounded priority queue held as a row of cells sorted from the highest priority
// (cell 0, served next) downwards; among equal priorities the oldest entry sits nearest
// cell 0. Each item is an insert (req_type 0) or a remove (req_type 1) and gives exactly
// one result item in the cycle after acceptance. Every cell compares its own entry with the
// new priority at once, so all cells update together on an insert or a remove and a new
// item is accepted every cycle while the result register is free or being drained. An insert
// into a full queue (count at the capacity in use, which saturates to 1..QUEUE_DEPTH) is
// rejected and flagged; a remove from an empty queue returns out_valid 0 with id and
// priority 0. held_count is the count after the item, low 5 bits. Capacity writes are taken
// any time and apply to later items; entries already held above a lowered capacity stay
// until removed.
module stable_max_priority_queue_core import smpq_pkg::*; #(
    parameter int QUEUE_DEPTH = SMPQ_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    smpq_req_if.sink         i_req,
    smpq_rsp_if.source       o_rsp
);

    // count needs to hold QUEUE_DEPTH itself
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    // compare width covers both the count and the 5-bit capacity register
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // capacity register
    logic [CAP_W-1:0] r_cap;

    // entry count
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // result register
    logic              r_rsp_valid;
    logic [ID_W-1:0]   r_out_id;
    logic [PRIO_W-1:0] r_out_prio;
    logic              r_out_valid;
    logic              r_ins_rej;
    logic [HELD_W-1:0] r_held;

    logic [CMP_W-1:0] w_cap_ext;
    logic [CMP_W-1:0] w_eff_cap;
    logic [CMP_W-1:0] w_cnt_ext;
    logic [CMP_W-1:0] w_ncnt_ext;
    logic             w_full;
    logic             w_empty;
    logic             w_accept;
    logic             w_is_ins;
    logic             w_is_rem;
    t_cell_ctl        w_ctl;

    // chain wiring
    t_entry w_entry   [QUEUE_DEPTH];
    logic   w_ge      [QUEUE_DEPTH];
    t_entry w_left    [QUEUE_DEPTH];
    logic   w_left_ge [QUEUE_DEPTH];
    t_entry w_right   [QUEUE_DEPTH];
    logic   w_occ     [QUEUE_DEPTH];

    // take a new item when the result register is empty or being emptied
    assign i_req.ready = i_rst_n && (!r_rsp_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    // effective capacity, saturated to 1..QUEUE_DEPTH
    always_comb begin
        w_cap_ext = CMP_W'(r_cap);
        if (w_cap_ext == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (w_cap_ext > CMP_W'(QUEUE_DEPTH)) begin
            w_eff_cap = CMP_W'(QUEUE_DEPTH);
        end else begin
            w_eff_cap = w_cap_ext;
        end
    end

    assign w_cnt_ext = CMP_W'(r_count);
    assign w_full    = (w_cnt_ext >= w_eff_cap);
    assign w_empty   = (r_count == '0);

    assign w_is_ins = w_accept && (i_req.req_type == REQ_INSERT);
    assign w_is_rem = w_accept && (i_req.req_type == REQ_REMOVE);

    assign w_ctl.ins            = w_is_ins && !w_full;
    assign w_ctl.rem            = w_is_rem && !w_empty;
    assign w_ctl.new_entry.id   = i_req.requester_id;
    assign w_ctl.new_entry.prio = i_req.priority_level;

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_ncnt_ext = CMP_W'(n_count);

    // row of cells, cell 0 holds the entry served next
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        assign w_occ[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            // nothing ahead of the head cell: the new entry lands here if it wins
            assign w_left[g]    = w_ctl.new_entry;
            assign w_left_ge[g] = 1'b1;
        end else begin : g_mid
            assign w_left[g]    = w_entry[g-1];
            assign w_left_ge[g] = w_ge[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right[g] = w_entry[g];
        end else begin : g_body
            assign w_right[g] = w_entry[g+1];
        end

        smpq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_occupied    (w_occ[g]),
            .i_left_entry  (w_left[g]),
            .i_left_ge     (w_left_ge[g]),
            .i_right_entry (w_right[g]),
            .o_entry       (w_entry[g]),
            .o_ge          (w_ge[g])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            r_count <= n_count;
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_id    <= w_ctl.rem ? w_entry[0].id : '0;
            r_out_prio  <= w_ctl.rem ? w_entry[0].prio : '0;
            r_out_valid <= w_ctl.rem;
            r_ins_rej   <= w_is_ins && w_full;
            r_held      <= w_ncnt_ext[HELD_W-1:0];
        end
    end

    assign o_rsp.valid           = r_rsp_valid;
    assign o_rsp.out_id          = r_out_id;
    assign o_rsp.out_priority    = r_out_prio;
    assign o_rsp.out_valid       = r_out_valid;
    assign o_rsp.insert_rejected = r_ins_rej;
    assign o_rsp.held_count      = r_held;

endmodule

// ----- src/smpq_chk.sv -----
// port-level checks for the stable max priority queue, bound to the top level
`timescale 1ns / 1ps
module smpq_chk import smpq_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic [ID_W-1:0]   i_out_id,
    input logic [PRIO_W-1:0] i_out_priority,
    input logic              i_out_valid,
    input logic              i_insert_rejected,
    input logic [HELD_W-1:0] i_held_count
);

    // every accepted item shows a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> i_rsp_valid)
        else $error("no result after accepted item");

    // a stalled result blocks new items
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |-> !i_req_ready)
        else $error("item accepted over a stalled result");

    // a result is never both a removal and a rejected insert
    a_excl_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_out_valid && i_insert_rejected))
        else $error("removal and rejection flagged together");

    // no entry returned means id and priority are zero
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_out_valid) |-> (i_out_id == '0 && i_out_priority == '0))
        else $error("payload not zero without an entry");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_held_count)))
        else $error("stalled result changed");

endmodule

bind stable_max_priority_queue_core smpq_chk u_smpq_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_out_id          (o_rsp.out_id),
    .i_out_priority    (o_rsp.out_priority),
    .i_out_valid       (o_rsp.out_valid),
    .i_insert_rejected (o_rsp.insert_rejected),
    .i_held_count      (o_rsp.held_count)
);

// ----- sim/stable_max_priority_queue_core_test.sv -----
// self-checking testbench for the stable max priority queue core
`timescale 1ns / 1ps
module stable_max_priority_queue_core_test import smpq_pkg::*; ();

    localparam int LONG_STALL = 80;

    // one queued request for the driver; a drain mark makes the sender wait for all results
    typedef struct {
        bit                drain;
        logic              kind;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_req_item;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic              hit;
        logic              rejected;
        logic [HELD_W-1:0] held;
    } t_result;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CAP_W-1:0] i_cfg_data = '0;

    // bus-side copies of what the driver and the receiver put out
    logic              drv_valid = 1'b0;
    logic              drv_kind = REQ_INSERT;
    logic [ID_W-1:0]   drv_id = '0;
    logic [PRIO_W-1:0] drv_prio = '0;
    logic              sink_ready = 1'b0;

    smpq_req_if req_bus ();
    smpq_rsp_if rsp_bus ();

    assign req_bus.valid          = drv_valid;
    assign req_bus.req_type       = drv_kind;
    assign req_bus.requester_id   = drv_id;
    assign req_bus.priority_level = drv_prio;
    assign rsp_bus.ready          = sink_ready;

    stable_max_priority_queue_core #(
        .QUEUE_DEPTH (SMPQ_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus)
    );

    // shadow of the queue: place 0 lowest priority, tail served next
    t_entry           shadow_entries [SMPQ_DEPTH];
    int               shadow_count;
    logic [CAP_W-1:0] shadow_cap;

    t_req_item request_backlog [$];
    t_result   awaited_results [$];

    int  n_offered = 0;
    int  n_accepted = 0;
    int  n_checked = 0;
    int  n_errors = 0;
    int  n_stored = 0;
    int  n_rejected = 0;
    int  n_served = 0;
    int  n_empty_removes = 0;
    int  n_cap_writes = 0;
    int  n_long_stalls = 0;
    int  n_drains = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  drain_wait = 1'b0;
    bit  long_stall_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results still awaited", awaited_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // mostly back to back, some short gaps, now and then a long one
    function automatic int pick_gap(input int idle_pct);
        if ($urandom_range(99) >= idle_pct) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // works out the result of one accepted request and updates the shadow queue
    function automatic t_result apply_request(input logic kind, input logic [ID_W-1:0] id,
                                              input logic [PRIO_W-1:0] prio);
        t_result r;
        int      limit;
        int      pos;
        r = '0;
        limit = int'(shadow_cap);
        if (limit < 1) limit = 1;
        if (limit > SMPQ_DEPTH) limit = SMPQ_DEPTH;
        if (kind == REQ_INSERT) begin
            if (shadow_count >= limit) begin
                r.rejected = 1'b1;
                n_rejected++;
            end else begin
                // new entry goes below every entry of equal or higher priority
                pos = 0;
                while (pos < shadow_count && shadow_entries[pos].prio < prio) pos++;
                for (int k = shadow_count; k > pos; k--) shadow_entries[k] = shadow_entries[k-1];
                shadow_entries[pos].id = id;
                shadow_entries[pos].prio = prio;
                shadow_count++;
                n_stored++;
            end
        end else if (shadow_count > 0) begin
            shadow_count--;
            r.id = shadow_entries[shadow_count].id;
            r.prio = shadow_entries[shadow_count].prio;
            r.hit = 1'b1;
            n_served++;
        end else begin
            n_empty_removes++;
        end
        r.held = shadow_count[HELD_W-1:0];
        return r;
    endfunction

    // sender: takes items from the backlog, holds each until it is taken
    always @(negedge i_clk) begin
        t_req_item it;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else if (!(drv_valid && n_accepted != n_offered)) begin
            if (gap_left > 0) begin
                gap_left--;
                drv_valid <= 1'b0;
            end else if (drain_wait) begin
                if (awaited_results.size() == 0) drain_wait = 1'b0;
                drv_valid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
                it = request_backlog.pop_front();
                if (it.drain) begin
                    drain_wait = 1'b1;
                    n_drains++;
                    drv_valid <= 1'b0;
                end else begin
                    drv_kind <= it.kind;
                    drv_id <= it.id;
                    drv_prio <= it.prio;
                    drv_valid <= 1'b1;
                    n_offered++;
                    gap_left = pick_gap(send_idle_pct);
                end
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            sink_ready <= 1'b0;
        end else if (long_stall_req) begin
            long_stall_req = 1'b0;
            stall_left = LONG_STALL - 1;
            n_long_stalls++;
            sink_ready <= 1'b0;
        end else begin
            stall_left = pick_gap(recv_idle_pct);
            if (stall_left > 0) begin
                stall_left--;
                sink_ready <= 1'b0;
            end else begin
                sink_ready <= 1'b1;
            end
        end
    end

    // monitor: checks results, then tracks capacity writes and accepted requests
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            shadow_count = 0;
            shadow_cap = CAP_RESET;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                got.id = rsp_bus.out_id;
                got.prio = rsp_bus.out_priority;
                got.hit = rsp_bus.out_valid;
                got.rejected = rsp_bus.insert_rejected;
                got.held = rsp_bus.held_count;
                if (awaited_results.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result: id %0d prio %0d valid %0b rej %0b held %0d",
                             $realtime, got.id, got.prio, got.hit, got.rejected, got.held);
                end else begin
                    want = awaited_results.pop_front();
                    n_checked++;
                    if (got !== want) begin
                        n_errors++;
                        $display("%0t: expected id %0d prio %0d valid %0b rej %0b held %0d",
                                 $realtime, want.id, want.prio, want.hit, want.rejected, want.held);
                        $display("%0t:   actual id %0d prio %0d valid %0b rej %0b held %0d",
                                 $realtime, got.id, got.prio, got.hit, got.rejected, got.held);
                    end
                end
            end
            if (i_cfg_we) shadow_cap = i_cfg_data;
            if (req_bus.valid && req_bus.ready) begin
                awaited_results.push_back(apply_request(req_bus.req_type, req_bus.requester_id,
                                                        req_bus.priority_level));
                n_accepted++;
            end
        end
    end

    task automatic queue_req(input logic kind, input int id, input int prio);
        t_req_item it;
        it.drain = 1'b0;
        it.kind = kind;
        it.id = ID_W'(id);
        it.prio = PRIO_W'(prio);
        request_backlog.push_back(it);
    endtask

    task automatic queue_drain();
        t_req_item it;
        it = '{drain: 1'b1, kind: REQ_INSERT, id: '0, prio: '0};
        request_backlog.push_back(it);
    endtask

    // bursts of inserts and bursts of removes so the queue swings between empty and full
    task automatic queue_mix(input int n);
        int  added;
        int  len;
        bit  insert_burst;
        bit  coarse_prio;
        int  prio;
        added = 0;
        while (added < n) begin
            insert_burst = ($urandom_range(99) < 55);
            coarse_prio = ($urandom_range(1) == 1);
            len = $urandom_range(1, 20);
            for (int j = 0; j < len && added < n; j++) begin
                // a coarse priority set gives many equal priorities
                prio = coarse_prio ? $urandom_range(3) * 85 : $urandom_range(255);
                if (($urandom_range(99) < 85) == insert_burst)
                    queue_req(REQ_INSERT, $urandom_range(1023), prio);
                else
                    queue_req(REQ_REMOVE, $urandom_range(1023), prio);
                added++;
            end
        end
    endtask

    // waits until nothing is queued or in flight, then a short settling pause
    task automatic wait_idle();
        while (request_backlog.size() > 0 || drain_wait || n_accepted != n_offered ||
               awaited_results.size() > 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_cap_writes++;
        @(posedge i_clk);
    endtask

    initial begin
        int caps [7];
        int nitems;
        caps = '{31, 1, 16, 0, 2, 9, 16};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset capacity: empty remove, field extremes, three equal priorities in order
        send_idle_pct = 20;
        recv_idle_pct = 20;
        queue_req(REQ_REMOVE, 1023, 255);
        queue_req(REQ_INSERT, 1023, 255);
        queue_req(REQ_INSERT, 0, 0);
        queue_req(REQ_INSERT, 341, 128);
        queue_req(REQ_INSERT, 682, 128);
        queue_req(REQ_INSERT, 1023, 128);
        queue_req(REQ_REMOVE, 0, 0);
        wait_idle();

        // capacity lowered under the count: rejects until removes make room
        write_capacity(5'd3);
        queue_req(REQ_INSERT, 5, 200);
        queue_req(REQ_REMOVE, 0, 0);
        queue_req(REQ_REMOVE, 0, 0);
        queue_req(REQ_INSERT, 10, 128);
        queue_req(REQ_INSERT, 11, 128);
        repeat (4) queue_req(REQ_REMOVE, 0, 0);
        wait_idle();

        // capacity zero acts as one place
        write_capacity(5'd0);
        queue_req(REQ_INSERT, 512, 1);
        queue_req(REQ_INSERT, 513, 254);
        queue_req(REQ_REMOVE, 0, 0);
        queue_req(REQ_REMOVE, 0, 0);
        wait_idle();

        // random phases; the queue keeps its contents across capacity changes
        for (int p = 0; p < 7; p++) begin
            write_capacity(CAP_W'(p == 3 ? $urandom_range(31) : caps[p]));
            nitems = 133;
            send_idle_pct = (p == 2 || p == 5) ? 0 : 30;
            recv_idle_pct = (p == 2 || p == 5) ? 0 : 30;
            if (p == 2) begin
                // receiver holds off while the sender keeps pushing, then a full drain
                long_stall_req = 1'b1;
                queue_mix(nitems / 2);
                queue_drain();
                queue_mix(nitems - nitems / 2);
            end else begin
                queue_mix(nitems);
            end
            wait_idle();
        end

        repeat (4) @(posedge i_clk);
        $display("ran %0d requests over %0d capacity writes: %0d stored, %0d rejected as full,",
                 n_accepted, n_cap_writes, n_stored, n_rejected);
        $display("%0d served, %0d removes on empty, %0d long stalls, %0d drains, %0d checked",
                 n_served, n_empty_removes, n_long_stalls, n_drains, n_checked);
        if (n_errors == 0 && awaited_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/smpq_pkg.sv
src/smpq_if.sv
src/smpq_cell.sv
src/stable_max_priority_queue_core.sv
src/smpq_chk.sv
sim/stable_max_priority_queue_core_test.sv
